[src/vdn_pkg.sv]
// shared types and constants for the vector dot and norm reduction core
`timescale 1ns / 1ps
`default_nettype none

package vdn_pkg;

    localparam int ELEM_WIDTH  = 32;
    localparam int ACC_WIDTH   = 64;
    localparam int ROOT_WIDTH  = 32;
    localparam int OP_WIDTH    = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [OP_WIDTH-1:0] OP_DOT  = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_NRM2 = 2'd1;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] x;
        logic signed [ELEM_WIDTH-1:0] y;
        logic                         last;
        logic [OP_WIDTH-1:0]          op;
    } t_item;

endpackage

`default_nettype wire

[src/vdn_front.sv]
// front stage: takes input transfers, sign-extends elements and tags the operation
`timescale 1ns / 1ps
`default_nettype none

module vdn_front
    import vdn_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [ELEM_WIDTH-1:0] i_x_value,
    input  wire logic [ELEM_WIDTH-1:0] i_y_value,
    input  wire logic                  i_last_element,
    input  wire logic [OP_WIDTH-1:0]   i_operation,
    output logic                       o_valid,
    output t_item                      o_item,
    input  wire logic                  i_ready
);

    logic                         r_valid;
    t_item                        r_item;
    t_item                        n_item;
    logic signed [DATA_WIDTH-1:0] x_low;
    logic signed [DATA_WIDTH-1:0] y_low;
    logic                         accept;

    assign x_low  = i_x_value[DATA_WIDTH-1:0];
    assign y_low  = i_y_value[DATA_WIDTH-1:0];
    assign o_full = r_valid && !i_ready;
    assign accept = i_push && !o_full;

    always_comb begin
        n_item.x    = ELEM_WIDTH'(x_low);
        n_item.y    = ELEM_WIDTH'(y_low);
        n_item.last = i_last_element;
        n_item.op   = i_operation;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[src/vdn_queue.sv]
// short item queue between the front stage and the reduction engine
`timescale 1ns / 1ps
`default_nettype none

module vdn_queue
    import vdn_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[src/vdn_back.sv]
// reduction engine: multiply, saturating accumulate, max tracking, square root, result register
`timescale 1ns / 1ps
`default_nettype none

module vdn_back
    import vdn_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_empty,
    input  wire t_item                       i_q_item,
    output logic                             o_q_pop,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic signed [ACC_WIDTH-1:0]      o_result_value,
    output logic                             o_overflow
);

    localparam logic [ELEM_WIDTH-1:0] MAX_MAG =
        ELEM_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam int ITER_W = $clog2(ROOT_WIDTH);
    localparam int REM_W  = ROOT_WIDTH + 2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_FIN  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;

    logic [1:0]                  r_state, n_state;

    logic                        r_s1_valid;
    logic signed [ACC_WIDTH-1:0] r_s1_prod;
    logic [ELEM_WIDTH-1:0]       r_s1_abs;
    logic                        r_s1_abs_sat;
    logic [OP_WIDTH-1:0]         r_s1_op;
    logic                        r_s1_last;

    logic signed [ACC_WIDTH-1:0] r_acc, n_acc;
    logic [ELEM_WIDTH-1:0]       r_largest, n_largest;
    logic                        r_sat, n_sat;
    logic [OP_WIDTH-1:0]         r_fin_op, n_fin_op;

    logic [ACC_WIDTH-1:0]        r_rad, n_rad;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [ROOT_WIDTH-1:0]       r_root, n_root;
    logic [ITER_W-1:0]           r_iter, n_iter;
    logic                        r_sqrt_done, n_sqrt_done;

    logic                        r_out_valid;
    logic signed [ACC_WIDTH-1:0] r_out_value, n_out_value;
    logic                        r_out_ovf, n_out_ovf;
    logic                        out_write;
    logic                        out_free;

    logic                        s1_fire;
    logic signed [ELEM_WIDTH-1:0] mul_b;
    logic [ELEM_WIDTH-1:0]       x_abs;
    logic [ACC_WIDTH-1:0]        sum;
    logic                        sum_ovf;
    logic [REM_W+1:0]            rem_shift;
    logic [REM_W+1:0]            trial;
    logic                        trial_ge;
    logic [ROOT_WIDTH-1:0]       root_clamp;
    logic                        root_sat;

    assign out_free = !r_out_valid || i_pop;
    assign s1_fire  = r_s1_valid && (r_state == ST_RUN);
    assign o_q_pop  = !i_q_empty && (!r_s1_valid || s1_fire);

    // stage 1: product and clamped magnitude
    assign mul_b = (i_q_item.op == OP_DOT) ? i_q_item.y : i_q_item.x;
    assign x_abs = i_q_item.x[ELEM_WIDTH-1] ? (~i_q_item.x + 1'b1) : i_q_item.x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_prod    <= i_q_item.x * mul_b;
            r_s1_abs     <= (x_abs > MAX_MAG) ? MAX_MAG : x_abs;
            r_s1_abs_sat <= (x_abs > MAX_MAG);
            r_s1_op      <= i_q_item.op;
            r_s1_last    <= i_q_item.last;
        end
    end

    // saturating add
    assign sum     = r_acc + r_s1_prod;
    assign sum_ovf = (r_acc[ACC_WIDTH-1] == r_s1_prod[ACC_WIDTH-1])
                     && (sum[ACC_WIDTH-1] != r_acc[ACC_WIDTH-1]);

    // one root bit per cycle
    assign rem_shift  = {r_rem, r_rad[ACC_WIDTH-1 -: 2]};
    assign trial      = {2'b00, r_root, 2'b01};
    assign trial_ge   = (rem_shift >= trial);
    assign root_sat   = (r_root > MAX_MAG);
    assign root_clamp = root_sat ? MAX_MAG : r_root;

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_largest   = r_largest;
        n_sat       = r_sat;
        n_fin_op    = r_fin_op;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_iter      = r_iter;
        n_sqrt_done = r_sqrt_done;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;
        out_write   = 1'b0;

        unique case (r_state)
            ST_RUN: begin
                if (s1_fire) begin
                    if (r_s1_op == OP_DOT || r_s1_op == OP_NRM2) begin
                        if (sum_ovf) begin
                            n_acc = r_acc[ACC_WIDTH-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                                       : {1'b0, {(ACC_WIDTH-1){1'b1}}};
                            n_sat = 1'b1;
                        end else begin
                            n_acc = sum;
                        end
                    end else begin
                        if (r_s1_abs_sat) begin
                            n_sat = 1'b1;
                        end
                        if (r_s1_abs > r_largest) begin
                            n_largest = r_s1_abs;
                        end
                    end
                    if (r_s1_last) begin
                        n_fin_op = r_s1_op;
                        n_state  = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (r_fin_op == OP_NRM2) begin
                    n_rad       = r_acc[ACC_WIDTH-1] ? '0 : r_acc;
                    n_rem       = '0;
                    n_root      = '0;
                    n_iter      = '0;
                    n_sqrt_done = 1'b0;
                    n_state     = ST_SQRT;
                end else if (out_free) begin
                    out_write   = 1'b1;
                    n_out_value = (r_fin_op == OP_DOT) ? r_acc
                                                       : ACC_WIDTH'(r_largest);
                    n_out_ovf   = r_sat;
                    n_acc       = '0;
                    n_largest   = '0;
                    n_sat       = 1'b0;
                    n_state     = ST_RUN;
                end
            end
            ST_SQRT: begin
                if (!r_sqrt_done) begin
                    n_rad  = r_rad << 2;
                    n_rem  = trial_ge ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
                    n_root = {r_root[ROOT_WIDTH-2:0], trial_ge};
                    n_iter = r_iter + 1'b1;
                    if (r_iter == ITER_W'(ROOT_WIDTH - 1)) begin
                        n_sqrt_done = 1'b1;
                    end
                end else if (out_free) begin
                    out_write   = 1'b1;
                    n_out_value = ACC_WIDTH'(root_clamp);
                    n_out_ovf   = r_sat || root_sat;
                    n_acc       = '0;
                    n_largest   = '0;
                    n_sat       = 1'b0;
                    n_state     = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_acc       <= '0;
            r_largest   <= '0;
            r_sat       <= 1'b0;
            r_sqrt_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_largest   <= n_largest;
            r_sat       <= n_sat;
            r_sqrt_done <= n_sqrt_done;
            if (out_write) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin_op    <= n_fin_op;
        r_rad       <= n_rad;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_iter      <= n_iter;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_empty        = !r_out_valid;
    assign o_result_value = r_out_value;
    assign o_overflow     = r_out_ovf;

`ifndef SYNTHESIS
    a_sqrt_only_for_nrm2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_fin_op == OP_NRM2))
        else $error("square root running for a non-norm vector");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_value)
                                     && $stable(r_out_ovf)))
        else $error("waiting result changed before transfer");

    a_no_stage_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (!r_s1_valid || s1_fire))
        else $error("stage 1 overwritten while holding an item");

    a_largest_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_largest <= MAX_MAG)
        else $error("largest magnitude above clamp limit");
`endif

endmodule

`default_nettype wire

[src/vector_dot_and_norm_reduction_core.sv]
// top level of the vector dot product and norm reduction core
//
// Streams element pairs (signed, DATA_WIDTH-8 fraction bits in the low DATA_WIDTH bits of each
// port) and reduces each vector by the operation register: 0 dot product (Q16.48 at the
// default width), 1 euclidean norm (floor square root, input format), 2 or 3 infinity norm.
// One result transfer follows the element marked last, with a sticky overflow flag for any
// saturation. Within a vector one element is taken per cycle while the queue has room: a
// registered multiplier feeds the saturating 64-bit accumulator. After the last element the
// engine forms a dot or infinity norm result, or for the euclidean norm first runs the
// bit-serial square root unit (32 iterations). A four-entry queue between the input stage
// and the engine keeps accepting elements of the next vector meanwhile. Write the operation
// register only while no vector is in flight.
`timescale 1ns / 1ps
`default_nettype none

module vector_dot_and_norm_reduction_core
    import vdn_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [OP_WIDTH-1:0]         i_cfg_wr_data,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic signed [ELEM_WIDTH-1:0] i_x_value,
    input  wire logic signed [ELEM_WIDTH-1:0] i_y_value,
    input  wire logic                        i_last_element,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic signed [ACC_WIDTH-1:0]      o_result_value,
    output logic                             o_overflow
);

    logic [OP_WIDTH-1:0] r_operation;
    logic                front_valid;
    t_item               front_item;
    logic                q_full;
    logic                q_empty;
    t_item               q_item;
    logic                q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= OP_DOT;
        end else if (i_cfg_wr_en) begin
            r_operation <= i_cfg_wr_data;
        end
    end

    vdn_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_last_element (i_last_element),
        .i_operation    (r_operation),
        .o_valid        (front_valid),
        .o_item         (front_item),
        .i_ready        (!q_full)
    );

    vdn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    vdn_back #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_result_value (o_result_value),
        .o_overflow     (o_overflow)
    );

endmodule

`default_nettype wire
